[rtl/ppm_peak_meter_envelope_macros.svh]
`ifndef PPM_PEAK_METER_ENVELOPE_MACROS_SVH
`define PPM_PEAK_METER_ENVELOPE_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define PPM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define PPM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ppm_pkg.sv]
package ppm_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int CH_BITS      = $clog2(NUM_CHANNELS);
   localparam int SAMPLE_BITS  = 24;
   localparam int COEF_BITS    = 24;
   localparam int ALPHA_BITS   = 16;
   localparam int GAIN_FRAC    = 22;
   localparam int ACTIVE_BITS  = 4;
   localparam int PROD_BITS    = 2 * COEF_BITS;
   localparam int MIX_SUM_BITS = SAMPLE_BITS + ALPHA_BITS;
   localparam int LEVEL_BITS   = PROD_BITS - GAIN_FRAC;
   localparam int ADDR_BITS    = 5;
   localparam int DATA_BITS    = 32;

   localparam logic [SAMPLE_BITS-1:0] FOLLOWER_MAX = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

   localparam logic                   PPM_MODE_RESET    = 1'b1;
   localparam logic                   FREEZE_RESET      = 1'b0;
   localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET      = ACTIVE_BITS'(8);
   localparam logic [COEF_BITS-1:0]   RELEASE_RESET     = COEF_BITS'(16775538);
   localparam logic [COEF_BITS-1:0]   ATTACK_SLOW_RESET = COEF_BITS'(69905);
   localparam logic [COEF_BITS-1:0]   ATTACK_FAST_RESET = COEF_BITS'(342535);
   localparam logic [COEF_BITS-1:0]   GAIN_RESET        = COEF_BITS'(4551190);
   localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET       = ALPHA_BITS'(39322);

   typedef enum logic [2:0] {
      REG_PPM_MODE    = 3'd0,
      REG_FREEZE      = 3'd1,
      REG_ACTIVE      = 3'd2,
      REG_RELEASE     = 3'd3,
      REG_ATTACK_SLOW = 3'd4,
      REG_ATTACK_FAST = 3'd5,
      REG_LEVEL_GAIN  = 3'd6,
      REG_MIX_ALPHA   = 3'd7
   } reg_index_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_READ   = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] slow;
      logic [SAMPLE_BITS-1:0] fast;
      logic [SAMPLE_BITS-1:0] hold;
   } entry_type;

endpackage

[rtl/ppm_peak_meter_envelope.sv]
// Multi-channel peak programme meter. Each req beat is either an audio sample, passed through
// on rsp with held_level zero, or a read, which returns and clears the channel's peak hold.
// Per-channel follower and hold state sits in one single-port memory with a registered read,
// so a beat reads its entry, works on it and writes it back before the next beat is taken.
// A PPM sample goes through entry read, decay, attack, mix, gain and write-back, over two
// shared 24x24 multipliers; reads, plain-mode, frozen and inactive-channel samples go from the
// entry read straight to the write-back. req_stall stays high from acceptance until the
// write-back, and a result is held while rsp_stall is high, with one result waiting in the
// output register while the next beat is worked on.
// Memory entries start at zero through per-entry valid bits; there is no clearing pass.
`include "ppm_peak_meter_envelope_macros.svh"

module ppm_peak_meter_envelope
   import ppm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [CH_BITS-1:0]            req_channel,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_through_sample,
   output logic [SAMPLE_BITS-1:0]        rsp_held_level,
   output logic                          rsp_is_read,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ADDR_BITS-1:0]          csr_paddr,
   input  logic [DATA_BITS-1:0]          csr_pwdata,
   output logic [DATA_BITS-1:0]          csr_prdata,
   output logic                          csr_pready
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_LOAD   = 7'b0000010,
      ST_DECAY  = 7'b0000100,
      ST_ATTACK = 7'b0001000,
      ST_MIX    = 7'b0010000,
      ST_GAIN   = 7'b0100000,
      ST_WRITE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic                   ppm_mode_ff, ppm_mode_in;
   logic                   freeze_ff, freeze_in;
   logic [ACTIVE_BITS-1:0] active_ff, active_in;
   logic [COEF_BITS-1:0]   release_ff, release_in;
   logic [COEF_BITS-1:0]   attack_slow_ff, attack_slow_in;
   logic [COEF_BITS-1:0]   attack_fast_ff, attack_fast_in;
   logic [COEF_BITS-1:0]   gain_ff, gain_in;
   logic [ALPHA_BITS-1:0]  alpha_ff, alpha_in;

   logic                          item_op_ff, item_op_in;
   logic [CH_BITS-1:0]            item_channel_ff, item_channel_in;
   logic signed [SAMPLE_BITS-1:0] item_sample_ff, item_sample_in;

   logic [SAMPLE_BITS-1:0] slow_ff, slow_in;
   logic [SAMPLE_BITS-1:0] fast_ff, fast_in;
   logic [SAMPLE_BITS-1:0] hold_ff, hold_in;
   logic [PROD_BITS-1:0]   prod_a_ff, prod_a_in;
   logic [PROD_BITS-1:0]   prod_b_ff, prod_b_in;

   logic [NUM_CHANNELS-1:0] valid_ff, valid_in;
   entry_type               meter_mem [NUM_CHANNELS];
   entry_type               rd_entry_ff;
   logic                    rd_valid_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic [SAMPLE_BITS-1:0]        rsp_level_ff, rsp_level_in;
   logic                          rsp_read_ff, rsp_read_in;

   logic                    req_accept;
   logic                    csr_write;
   logic                    out_blocked;
   logic                    metered;
   logic                    mem_write;
   entry_type               wr_entry;
   logic [SAMPLE_BITS-1:0]  mag;
   logic [COEF_BITS-1:0]    mul_a_x, mul_a_y, mul_b_x, mul_b_y;
   logic [SAMPLE_BITS-1:0]  dec_slow, dec_fast, diff_slow, diff_fast;
   logic [SAMPLE_BITS-1:0]  new_slow, new_fast;
   logic [ALPHA_BITS:0]     alpha_inv;
   logic [MIX_SUM_BITS-1:0] mix_sum;
   logic [SAMPLE_BITS-1:0]  mix;
   logic [LEVEL_BITS-1:0]   level_wide;
   logic [SAMPLE_BITS-1:0]  level_sat;
   logic [SAMPLE_BITS-1:0]  level;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign out_blocked = rsp_valid_ff && rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_through_sample = rsp_sample_ff;
   assign rsp_held_level     = rsp_level_ff;
   assign rsp_is_read        = rsp_read_ff;

   assign metered = (item_op_ff == OP_SAMPLE) && !freeze_ff &&
                    ({1'b0, item_channel_ff} < active_ff);

   assign mag = item_sample_ff[SAMPLE_BITS-1] ? (~unsigned'(item_sample_ff) + 1'b1)
                                              : unsigned'(item_sample_ff);

   assign dec_slow  = prod_a_ff[PROD_BITS-1:COEF_BITS];
   assign dec_fast  = prod_b_ff[PROD_BITS-1:COEF_BITS];
   assign diff_slow = (mag > dec_slow) ? (mag - dec_slow) : '0;
   assign diff_fast = (mag > dec_fast) ? (mag - dec_fast) : '0;
   assign new_slow  = slow_ff + prod_a_ff[PROD_BITS-1:COEF_BITS];
   assign new_fast  = fast_ff + prod_b_ff[PROD_BITS-1:COEF_BITS];
   assign alpha_inv = (ALPHA_BITS+1)'(1) << ALPHA_BITS;
   assign mix_sum   = prod_a_ff[MIX_SUM_BITS-1:0] + prod_b_ff[MIX_SUM_BITS-1:0];
   assign mix       = mix_sum[MIX_SUM_BITS-1:ALPHA_BITS];

   assign level_wide = prod_a_ff[PROD_BITS-1:GAIN_FRAC];
   assign level_sat  = (|level_wide[LEVEL_BITS-1:SAMPLE_BITS]) ? '1
                                                               : level_wide[SAMPLE_BITS-1:0];
   assign level      = ppm_mode_ff ? level_sat : mag;

   assign mem_write     = (state_ff == ST_WRITE) && !out_blocked;
   assign wr_entry.slow = slow_ff;
   assign wr_entry.fast = fast_ff;
   assign wr_entry.hold = (item_op_ff == OP_READ) ? '0 :
                          (metered && (level > hold_ff)) ? level : hold_ff;

   // multiplier operand selection, one pair per follower lane
   always_comb begin
      mul_a_x = '0;
      mul_a_y = '0;
      mul_b_x = '0;
      mul_b_y = '0;
      case (state_ff)
         ST_DECAY: begin
            mul_a_x = slow_ff;
            mul_a_y = release_ff;
            mul_b_x = fast_ff;
            mul_b_y = release_ff;
         end
         ST_ATTACK: begin
            mul_a_x = diff_slow;
            mul_a_y = attack_slow_ff;
            mul_b_x = diff_fast;
            mul_b_y = attack_fast_ff;
         end
         ST_MIX: begin
            mul_a_x = new_slow;
            mul_a_y = COEF_BITS'(alpha_ff);
            mul_b_x = new_fast;
            mul_b_y = COEF_BITS'(alpha_inv - {1'b0, alpha_ff});
         end
         ST_GAIN: begin
            mul_a_x = mix;
            mul_a_y = gain_ff;
         end
         default: begin
            mul_a_x = '0;
         end
      endcase
   end

   always_comb begin
      ppm_mode_in    = ppm_mode_ff;
      freeze_in      = freeze_ff;
      active_in      = active_ff;
      release_in     = release_ff;
      attack_slow_in = attack_slow_ff;
      attack_fast_in = attack_fast_ff;
      gain_in        = gain_ff;
      alpha_in       = alpha_ff;
      if (csr_write) begin
         case (reg_index_type'(csr_paddr[4:2]))
            REG_PPM_MODE:    ppm_mode_in    = csr_pwdata[0];
            REG_FREEZE:      freeze_in      = csr_pwdata[0];
            REG_ACTIVE:      active_in      = csr_pwdata[ACTIVE_BITS-1:0];
            REG_RELEASE:     release_in     = csr_pwdata[COEF_BITS-1:0];
            REG_ATTACK_SLOW: attack_slow_in = csr_pwdata[COEF_BITS-1:0];
            REG_ATTACK_FAST: attack_fast_in = csr_pwdata[COEF_BITS-1:0];
            REG_LEVEL_GAIN:  gain_in        = csr_pwdata[COEF_BITS-1:0];
            REG_MIX_ALPHA:   alpha_in       = csr_pwdata[ALPHA_BITS-1:0];
            default:         alpha_in       = alpha_ff;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_index_type'(csr_paddr[4:2]))
         REG_PPM_MODE:    csr_prdata = DATA_BITS'(ppm_mode_ff);
         REG_FREEZE:      csr_prdata = DATA_BITS'(freeze_ff);
         REG_ACTIVE:      csr_prdata = DATA_BITS'(active_ff);
         REG_RELEASE:     csr_prdata = DATA_BITS'(release_ff);
         REG_ATTACK_SLOW: csr_prdata = DATA_BITS'(attack_slow_ff);
         REG_ATTACK_FAST: csr_prdata = DATA_BITS'(attack_fast_ff);
         REG_LEVEL_GAIN:  csr_prdata = DATA_BITS'(gain_ff);
         REG_MIX_ALPHA:   csr_prdata = DATA_BITS'(alpha_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      item_op_in      = item_op_ff;
      item_channel_in = item_channel_ff;
      item_sample_in  = item_sample_ff;
      slow_in         = slow_ff;
      fast_in         = fast_ff;
      hold_in         = hold_ff;
      prod_a_in       = PROD_BITS'(mul_a_x) * PROD_BITS'(mul_a_y);
      prod_b_in       = PROD_BITS'(mul_b_x) * PROD_BITS'(mul_b_y);
      valid_in        = valid_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_sample_in   = rsp_sample_ff;
      rsp_level_in    = rsp_level_ff;
      rsp_read_in     = rsp_read_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_op_in      = req_opcode;
               item_channel_in = req_channel;
               item_sample_in  = req_sample;
               state_in        = ST_LOAD;
            end
         end
         ST_LOAD: begin
            slow_in = rd_valid_ff ? rd_entry_ff.slow : '0;
            fast_in = rd_valid_ff ? rd_entry_ff.fast : '0;
            hold_in = rd_valid_ff ? rd_entry_ff.hold : '0;
            state_in = (metered && ppm_mode_ff) ? ST_DECAY : ST_WRITE;
         end
         ST_DECAY: begin
            state_in = ST_ATTACK;
         end
         ST_ATTACK: begin
            slow_in  = dec_slow;
            fast_in  = dec_fast;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            slow_in  = new_slow;
            fast_in  = new_fast;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // keep the gain product while the result register is full
            prod_a_in = prod_a_ff;
            prod_b_in = prod_b_ff;
            if (!out_blocked) begin
               valid_in[item_channel_ff] = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_read_in   = (item_op_ff == OP_READ);
               rsp_sample_in = (item_op_ff == OP_READ) ? '0 : item_sample_ff;
               rsp_level_in  = (item_op_ff == OP_READ) ? hold_ff : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         ppm_mode_ff    <= PPM_MODE_RESET;
         freeze_ff      <= FREEZE_RESET;
         active_ff      <= ACTIVE_RESET;
         release_ff     <= RELEASE_RESET;
         attack_slow_ff <= ATTACK_SLOW_RESET;
         attack_fast_ff <= ATTACK_FAST_RESET;
         gain_ff        <= GAIN_RESET;
         alpha_ff       <= ALPHA_RESET;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         ppm_mode_ff    <= ppm_mode_in;
         freeze_ff      <= freeze_in;
         active_ff      <= active_in;
         release_ff     <= release_in;
         attack_slow_ff <= attack_slow_in;
         attack_fast_ff <= attack_fast_in;
         gain_ff        <= gain_in;
         alpha_ff       <= alpha_in;
      end
   end

   always_ff @(posedge clock) begin
      item_op_ff      <= item_op_in;
      item_channel_ff <= item_channel_in;
      item_sample_ff  <= item_sample_in;
      slow_ff         <= slow_in;
      fast_ff         <= fast_in;
      hold_ff         <= hold_in;
      prod_a_ff       <= prod_a_in;
      prod_b_ff       <= prod_b_in;
      rsp_sample_ff   <= rsp_sample_in;
      rsp_level_ff    <= rsp_level_in;
      rsp_read_ff     <= rsp_read_in;
   end

   // channel state memory, registered read on acceptance
   always_ff @(posedge clock) begin
      if (mem_write) begin
         meter_mem[item_channel_ff] <= wr_entry;
      end
      if (req_accept) begin
         rd_entry_ff <= meter_mem[req_channel];
         rd_valid_ff <= valid_ff[req_channel];
      end
   end

   `PPM_ASSERT_NEXT(a_accept_loads, req_accept, state_ff == ST_LOAD, "accepted beat did not start an entry read")
   `PPM_ASSERT_NEXT(a_write_returns, mem_write, rsp_valid_ff && state_ff == ST_IDLE, "write-back without a result")
   `PPM_ASSERT_NOW(a_rsp_fields, rsp_valid_ff, rsp_read_ff ? (rsp_sample_ff == '0) : (rsp_level_ff == '0), "result carries both sample and level")
   `PPM_ASSERT_NOW(a_follower_range, state_ff == ST_WRITE, slow_ff <= FOLLOWER_MAX && fast_ff <= FOLLOWER_MAX, "follower above full scale")

endmodule

[dv/ppm_peak_meter_envelope_test.sv]
`timescale 1ns / 1ps

module ppm_peak_meter_envelope_test;
   import ppm_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int unsigned HOLD_OFF_AT     = 500;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned RANDOM_PHASES   = 11;

   localparam logic [SAMPLE_BITS-1:0] LEVEL_TOP = '1;
   localparam logic [SAMPLE_BITS-1:0] SMP_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SMP_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef struct {
      opcode_type             op;
      logic [CH_BITS-1:0]     ch;
      logic [SAMPLE_BITS-1:0] smp;
   } meter_beat_type;

   typedef struct {
      logic [SAMPLE_BITS-1:0] through;
      logic [SAMPLE_BITS-1:0] held;
      logic                   is_read;
   } meter_result_type;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_stall;
   logic                          req_opcode  = 1'b0;
   logic [CH_BITS-1:0]            req_channel = '0;
   logic signed [SAMPLE_BITS-1:0] req_sample  = '0;
   logic                          rsp_valid;
   logic                          rsp_stall   = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_through_sample;
   logic [SAMPLE_BITS-1:0]        rsp_held_level;
   logic                          rsp_is_read;
   logic                          csr_psel    = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite  = 1'b0;
   logic [ADDR_BITS-1:0]          csr_paddr   = '0;
   logic [DATA_BITS-1:0]          csr_pwdata  = '0;
   logic [DATA_BITS-1:0]          csr_prdata;
   logic                          csr_pready;

   // meter settings as last written
   logic                   ppm_on       = PPM_MODE_RESET;
   logic                   frozen       = FREEZE_RESET;
   logic [ACTIVE_BITS-1:0] active_count = ACTIVE_RESET;
   logic [COEF_BITS-1:0]   release_k    = RELEASE_RESET;
   logic [COEF_BITS-1:0]   slow_k       = ATTACK_SLOW_RESET;
   logic [COEF_BITS-1:0]   fast_k       = ATTACK_FAST_RESET;
   logic [COEF_BITS-1:0]   gain_k       = GAIN_RESET;
   logic [ALPHA_BITS-1:0]  alpha_k      = ALPHA_RESET;

   logic [SAMPLE_BITS-1:0] slow_env  [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] fast_env  [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] peak_held [NUM_CHANNELS];

   meter_beat_type   pending_beats[$];
   meter_result_type expected_readings[$];
   meter_beat_type   on_wire;

   bit          no_gaps = 1'b0;
   int unsigned send_wait;
   int unsigned recv_wait;
   int unsigned results_seen = 0;
   int unsigned failures     = 0;
   int unsigned cycle_count  = 0;

   ppm_peak_meter_envelope dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [SAMPLE_BITS-1:0] ballistic_step(logic [SAMPLE_BITS-1:0] env,
                                                             logic [SAMPLE_BITS-1:0] mag,
                                                             logic [COEF_BITS-1:0] attack);
      logic [63:0] y;
      y = (64'(env) * 64'(release_k)) >> COEF_BITS;
      if (64'(mag) > y) begin
         y = y + ((64'(attack) * (64'(mag) - y)) >> COEF_BITS);
      end
      return y[SAMPLE_BITS-1:0];
   endfunction

   function automatic meter_result_type meter_response(meter_beat_type b);
      meter_result_type       r;
      logic [SAMPLE_BITS:0]   mag;
      logic [SAMPLE_BITS-1:0] s;
      logic [SAMPLE_BITS-1:0] f;
      logic [SAMPLE_BITS-1:0] level;
      logic [63:0]            mix;
      logic [63:0]            lvl;
      r.through = '0;
      r.held    = '0;
      r.is_read = 1'b0;
      if (b.op == OP_READ) begin
         r.held    = peak_held[b.ch];
         r.is_read = 1'b1;
         peak_held[b.ch] = '0;
         return r;
      end
      r.through = b.smp;
      if (frozen || ACTIVE_BITS'(b.ch) >= active_count) begin
         return r;
      end
      mag = {1'b0, b.smp};
      if (b.smp[SAMPLE_BITS-1]) begin
         mag = {1'b1, {SAMPLE_BITS{1'b0}}} - mag;
      end
      if (ppm_on) begin
         s = ballistic_step(slow_env[b.ch], mag[SAMPLE_BITS-1:0], slow_k);
         f = ballistic_step(fast_env[b.ch], mag[SAMPLE_BITS-1:0], fast_k);
         slow_env[b.ch] = s;
         fast_env[b.ch] = f;
         mix = (64'(alpha_k) * 64'(s) + ((64'(1) << ALPHA_BITS) - 64'(alpha_k)) * 64'(f))
               >> ALPHA_BITS;
         lvl = (64'(gain_k) * mix) >> GAIN_FRAC;
         level = (lvl > 64'(LEVEL_TOP)) ? LEVEL_TOP : lvl[SAMPLE_BITS-1:0];
      end else begin
         level = mag[SAMPLE_BITS-1:0];
      end
      if (level > peak_held[b.ch]) begin
         peak_held[b.ch] = level;
      end
      return r;
   endfunction

   function automatic logic [COEF_BITS-1:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return COEF_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [COEF_BITS-1:0] pick_release();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2, 3: return {8'hFF, 16'($urandom)};
         default: return COEF_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [ALPHA_BITS-1:0] pick_alpha();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         default: return ALPHA_BITS'($urandom);
      endcase
   endfunction

   task automatic csr_write(reg_index_type idx, logic [DATA_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_BITS'(4 * int'(idx));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_PPM_MODE:    ppm_on       = value[0];
         REG_FREEZE:      frozen       = value[0];
         REG_ACTIVE:      active_count = value[ACTIVE_BITS-1:0];
         REG_RELEASE:     release_k    = value[COEF_BITS-1:0];
         REG_ATTACK_SLOW: slow_k       = value[COEF_BITS-1:0];
         REG_ATTACK_FAST: fast_k       = value[COEF_BITS-1:0];
         REG_LEVEL_GAIN:  gain_k       = value[COEF_BITS-1:0];
         REG_MIX_ALPHA:   alpha_k      = value[ALPHA_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic program_meter(logic mode, logic frz, logic [ACTIVE_BITS-1:0] act,
                                logic [COEF_BITS-1:0] rel, logic [COEF_BITS-1:0] a_slow,
                                logic [COEF_BITS-1:0] a_fast, logic [COEF_BITS-1:0] gain,
                                logic [ALPHA_BITS-1:0] alpha);
      csr_write(REG_PPM_MODE, DATA_BITS'(mode));
      csr_write(REG_FREEZE, DATA_BITS'(frz));
      csr_write(REG_ACTIVE, DATA_BITS'(act));
      csr_write(REG_RELEASE, DATA_BITS'(rel));
      csr_write(REG_ATTACK_SLOW, DATA_BITS'(a_slow));
      csr_write(REG_ATTACK_FAST, DATA_BITS'(a_fast));
      csr_write(REG_LEVEL_GAIN, DATA_BITS'(gain));
      csr_write(REG_MIX_ALPHA, DATA_BITS'(alpha));
      @(negedge clock);
   endtask

   // wait for the meter to go quiet before touching its settings
   task automatic settle();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_valid || expected_readings.size() != 0);
      repeat (10) @(negedge clock);
   endtask

   task automatic offer(opcode_type op, int unsigned ch, logic [SAMPLE_BITS-1:0] smp);
      meter_beat_type b;
      b.op  = op;
      b.ch  = CH_BITS'(ch);
      b.smp = smp;
      pending_beats.push_back(b);
   endtask

   task automatic random_phase(int unsigned count);
      meter_beat_type     b;
      logic [CH_BITS-1:0] focus;
      settle();
      program_meter($urandom_range(0, 3) != 0, $urandom_range(0, 7) == 0,
                    ($urandom_range(0, 2) == 0) ?
                       ACTIVE_BITS'($urandom_range(0, (1 << ACTIVE_BITS) - 1)) : ACTIVE_RESET,
                    pick_release(), pick_coef(), pick_coef(), pick_coef(), pick_alpha());
      no_gaps = ($urandom_range(0, 3) == 0);
      focus = CH_BITS'($urandom_range(0, NUM_CHANNELS - 1));
      repeat (count) begin
         b.op = ($urandom_range(0, 4) == 0) ? OP_READ : OP_SAMPLE;
         b.ch = ($urandom_range(0, 1) == 0) ? focus
                                            : CH_BITS'($urandom_range(0, NUM_CHANNELS - 1));
         case ($urandom_range(0, 5))
            0: b.smp = SMP_MIN;
            1: b.smp = SMP_MAX;
            2: b.smp = SAMPLE_BITS'($urandom_range(0, 511)) - SAMPLE_BITS'(256);
            default: b.smp = SAMPLE_BITS'($urandom);
         endcase
         pending_beats.push_back(b);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            slow_env[c]  = '0;
            fast_env[c]  = '0;
            peak_held[c] = '0;
         end
      end else begin
         if (req_valid && !req_stall) begin
            expected_readings.push_back(meter_response(on_wire));
            send_wait = no_gaps ? 0 : $urandom_range(0, 14);
         end else if (!req_valid && send_wait > 0) begin
            send_wait--;
         end
         if (!req_valid || !req_stall) begin
            if (send_wait == 0 && pending_beats.size() != 0) begin
               on_wire = pending_beats.pop_front();
               req_valid   <= 1'b1;
               req_opcode  <= on_wire.op;
               req_channel <= on_wire.ch;
               req_sample  <= on_wire.smp;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      meter_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_readings.size() == 0) begin
               $display("%0t: unexpected beat, through %h held %h read %b", $time,
                        rsp_through_sample, rsp_held_level, rsp_is_read);
               failures++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_through_sample !== want.through) begin
                  $display("%0t: through_sample expected %h actual %h", $time,
                           want.through, rsp_through_sample);
                  failures++;
               end
               if (rsp_held_level !== want.held) begin
                  $display("%0t: held_level expected %h actual %h", $time,
                           want.held, rsp_held_level);
                  failures++;
               end
               if (rsp_is_read !== want.is_read) begin
                  $display("%0t: is_read expected %b actual %b", $time,
                           want.is_read, rsp_is_read);
                  failures++;
               end
            end
            recv_wait = no_gaps ? 0 : $urandom_range(0, 14);
            // long hold-off so the meter backs up into its input
            if (results_seen == HOLD_OFF_AT) begin
               recv_wait = HOLD_OFF_CYCLES;
            end
         end else if (recv_wait > 0) begin
            recv_wait--;
         end
         rsp_stall <= (recv_wait != 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // power-on settings, extremes of the sample
      offer(OP_SAMPLE, 0, SMP_MAX);
      offer(OP_SAMPLE, 0, SMP_MIN);
      offer(OP_SAMPLE, 0, '0);
      offer(OP_SAMPLE, 1, '1);
      offer(OP_SAMPLE, 1, SAMPLE_BITS'(1));
      offer(OP_SAMPLE, 5, SAMPLE_BITS'(24'h400000));
      offer(OP_SAMPLE, 6, SMP_MAX);
      offer(OP_SAMPLE, 7, SMP_MIN);
      offer(OP_READ, 0, '0);
      offer(OP_READ, 0, '0);
      offer(OP_READ, 1, '0);
      offer(OP_READ, 7, '0);
      offer(OP_READ, 3, '1);

      // frozen: samples pass, reads still clear
      settle();
      program_meter(1'b1, 1'b1, ACTIVE_RESET, RELEASE_RESET, ATTACK_SLOW_RESET,
                    ATTACK_FAST_RESET, GAIN_RESET, ALPHA_RESET);
      offer(OP_SAMPLE, 5, SMP_MAX);
      offer(OP_READ, 5, '0);

      // plain mode, two channels active
      settle();
      program_meter(1'b0, 1'b0, ACTIVE_BITS'(2), RELEASE_RESET, ATTACK_SLOW_RESET,
                    ATTACK_FAST_RESET, GAIN_RESET, ALPHA_RESET);
      offer(OP_SAMPLE, 1, SMP_MIN);
      offer(OP_SAMPLE, 0, SAMPLE_BITS'(24'h123456));
      offer(OP_SAMPLE, 4, SMP_MAX);
      offer(OP_READ, 1, '0);
      offer(OP_READ, 4, '0);
      offer(OP_READ, 6, '0);

      // no release, full attack, full gain: level saturates
      settle();
      program_meter(1'b1, 1'b0, '1, '0, '1, '1, '1, '0);
      offer(OP_SAMPLE, 3, SMP_MIN);
      offer(OP_SAMPLE, 3, SMP_MAX);
      offer(OP_READ, 3, '0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         random_phase($urandom_range(80, 120));
      end

      settle();
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/ppm_pkg.sv
rtl/ppm_peak_meter_envelope.sv
dv/ppm_peak_meter_envelope_test.sv
